// File: rtl/hcs_pkg.sv
// Shared types and constants for the hourly chime striker.
// No dependencies; used by every module under rtl/.
package hcs_pkg;

  // Operation codes on the input stream
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_RING  = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SWING_PERIOD = 2'd0;
  localparam logic [1:0] REG_HAMMER_ON    = 2'd1;
  localparam logic [1:0] REG_FIRST_HOUR   = 2'd2;
  localparam logic [1:0] REG_LAST_HOUR    = 2'd3;

  // Register reset values
  localparam logic [15:0] SWING_PERIOD_RST = 16'd4000;
  localparam logic [15:0] HAMMER_ON_RST    = 16'd350;
  localparam logic [4:0]  FIRST_HOUR_RST   = 5'd8;
  localparam logic [4:0]  LAST_HOUR_RST    = 5'd22;

  // Clock-face constants
  localparam logic [5:0] HOURS_PER_FACE = 6'd12;
  localparam logic [5:0] LAST_MINUTE    = 6'd59;

  typedef struct packed {
    logic [15:0] swing_period_ms;
    logic [15:0] strike_hold_ms;
    logic [4:0]  first_hour;
    logic [4:0]  last_hour;
  } cfg_t;

  // Decoded request from one item
  typedef struct packed {
    logic       tick;
    logic       start;
    logic [7:0] count;
  } req_t;

  // Result of one item
  typedef struct packed {
    logic       rejected;
    logic [7:0] strikes_remaining;
    logic       busy_res;
    logic       hammer;
  } res_t;

endpackage

// File: rtl/hcs_req_decode.sv
// Turns one input item into a tick or a start request with a strike count.
// Depends on hcs_pkg.
module hcs_req_decode (
  input  logic [1:0]    operation,
  input  logic [4:0]    hour_now,
  input  logic [5:0]    minute_now,
  input  logic [7:0]    ring_count,
  input  hcs_pkg::cfg_t cfg,
  output hcs_pkg::req_t req
);

  logic       check;
  logic [5:0] hr;
  logic       in_window;
  logic [5:0] hr_mod;
  logic [5:0] strikes;

  always_comb begin
    check = 1'b0;
    hr    = 6'd0;
    if (minute_now == 6'd0) begin
      check = 1'b1;
      hr    = {1'b0, hour_now};
    end else if (minute_now == hcs_pkg::LAST_MINUTE) begin
      check = 1'b1;
      hr    = {1'b0, hour_now} + 6'd1;
    end
  end

  assign in_window = (hr >= {1'b0, cfg.first_hour}) && (hr <= {1'b0, cfg.last_hour});

  // hr is at most 32, so two conditional subtracts give the remainder
  always_comb begin
    if (hr >= (hcs_pkg::HOURS_PER_FACE << 1)) begin
      hr_mod = hr - (hcs_pkg::HOURS_PER_FACE << 1);
    end else if (hr >= hcs_pkg::HOURS_PER_FACE) begin
      hr_mod = hr - hcs_pkg::HOURS_PER_FACE;
    end else begin
      hr_mod = hr;
    end
  end

  assign strikes = (hr_mod == 6'd0) ? hcs_pkg::HOURS_PER_FACE : hr_mod;

  always_comb begin
    req = '0;
    case (operation)
      hcs_pkg::OP_TICK: begin
        req.tick = 1'b1;
      end
      hcs_pkg::OP_CHECK: begin
        req.start = check && in_window;
        req.count = {2'b00, strikes};
      end
      hcs_pkg::OP_RING: begin
        req.start = (ring_count != 8'd0);
        req.count = ring_count;
      end
      default: begin
        req = '0;
      end
    endcase
  end

endmodule

// File: rtl/hcs_strike_engine.sv
// Strike run state (strikes left, phase timer, hammer phase) and its update.
// Depends on hcs_pkg.
module hcs_strike_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  hcs_pkg::req_t req,
  input  hcs_pkg::cfg_t cfg,
  output hcs_pkg::res_t res,
  output logic [7:0]    strikes_left
);

  logic [7:0]  left_r,  left_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        phase_r, phase_nxt;
  logic        rej;
  logic        busy;
  logic [15:0] off_ms;
  logic [7:0]  left_dec;

  assign busy     = (left_r != 8'd0);
  assign off_ms   = (cfg.swing_period_ms > cfg.strike_hold_ms) ?
                    (cfg.swing_period_ms - cfg.strike_hold_ms) : 16'd0;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    left_nxt  = left_r;
    timer_nxt = timer_r;
    phase_nxt = phase_r;
    rej       = 1'b0;
    if (req.tick) begin
      if (busy) begin
        if (timer_r > 16'd1) begin
          timer_nxt = timer_r - 16'd1;
        end else if (phase_r) begin
          phase_nxt = 1'b0;
          timer_nxt = off_ms;
        end else begin
          left_nxt = left_dec;
          if (left_dec != 8'd0) begin
            phase_nxt = 1'b1;
            timer_nxt = cfg.strike_hold_ms;
          end else begin
            timer_nxt = 16'd0;
          end
        end
      end
    end else if (req.start) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        left_nxt  = req.count;
        phase_nxt = 1'b1;
        timer_nxt = cfg.strike_hold_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= 8'd0;
      timer_r <= 16'd0;
      phase_r <= 1'b0;
    end else if (en) begin
      left_r  <= left_nxt;
      timer_r <= timer_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign res.hammer            = phase_nxt;
  assign res.busy_res          = (left_nxt != 8'd0);
  assign res.strikes_remaining = left_nxt;
  assign res.rejected          = rej;
  assign strikes_left          = left_r;

endmodule

// File: rtl/hourly_chime_striker_core.sv
// Top level of the hourly chime striker: stream ports, APB registers,
// input stage and result register. Depends on hcs_pkg, hcs_req_decode,
// hcs_strike_engine.
//
// Usage:
//  - in_* stream: one item per transfer (tick, time check or ring now).
//    Every accepted item produces exactly one result on out_*.
//  - out_* stream: hammer level, busy flag, strikes left and reject flag
//    after that item. The hammer drive is out_tdata[0] of each result.
//  - cfg_* APB port: four registers at byte offsets 0, 4, 8, 12. Write
//    them only while no item is in flight.
// Path from input transfer to result valid: input register, then the
//   strike state update feeding the result register.
// Throughput: one item per cycle while out_tready is high; the whole state
//   update is one short compare/decrement path; back-to-back items never wait.
// Stall: while out_tready is low the result register holds; an empty input
//   register still takes one more item, then in_tready drops until the
//   result is taken.
// Reset (rst_n low, synchronous): registers return to 4000/350/8/22, the
//   strike run is cleared (hammer low, idle) and both stages empty.
module hourly_chime_striker_core (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: operation[1:0], hour_now[6:2], minute_now[12:7],
  //           ring_count[20:13], zero[23:21]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: hammer[0], busy_res[1], strikes_remaining[9:2],
  //            rejected[10], zero[15:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers
  hcs_pkg::cfg_t cfg_r;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swing_period_ms <= hcs_pkg::SWING_PERIOD_RST;
      cfg_r.strike_hold_ms  <= hcs_pkg::HAMMER_ON_RST;
      cfg_r.first_hour      <= hcs_pkg::FIRST_HOUR_RST;
      cfg_r.last_hour       <= hcs_pkg::LAST_HOUR_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hcs_pkg::REG_SWING_PERIOD: cfg_r.swing_period_ms <= cfg_pwdata[15:0];
        hcs_pkg::REG_HAMMER_ON:    cfg_r.strike_hold_ms  <= cfg_pwdata[15:0];
        hcs_pkg::REG_FIRST_HOUR:   cfg_r.first_hour      <= cfg_pwdata[4:0];
        hcs_pkg::REG_LAST_HOUR:    cfg_r.last_hour       <= cfg_pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hcs_pkg::REG_SWING_PERIOD: cfg_prdata = {16'd0, cfg_r.swing_period_ms};
      hcs_pkg::REG_HAMMER_ON:    cfg_prdata = {16'd0, cfg_r.strike_hold_ms};
      hcs_pkg::REG_FIRST_HOUR:   cfg_prdata = {27'd0, cfg_r.first_hour};
      hcs_pkg::REG_LAST_HOUR:    cfg_prdata = {27'd0, cfg_r.last_hour};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline control: result register advances when empty or being taken
  logic        s1_valid_r;
  logic [20:0] s1_data_r;
  logic        out_valid_r;
  logic [10:0] out_data_r;
  logic        advance;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[20:0];
    end
  end

  // Decode and strike state update
  hcs_pkg::req_t req;
  hcs_pkg::res_t res;
  logic [7:0]    strikes_left;
  logic          step;

  assign step = s1_valid_r && advance;

  hcs_req_decode u_decode (
    .operation  (s1_data_r[1:0]),
    .hour_now   (s1_data_r[6:2]),
    .minute_now (s1_data_r[12:7]),
    .ring_count (s1_data_r[20:13]),
    .cfg        (cfg_r),
    .req        (req)
  );

  hcs_strike_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (step),
    .req          (req),
    .cfg          (cfg_r),
    .res          (res),
    .strikes_left (strikes_left)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

  // Assertions
  a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[1])
    else $error("reject reported while idle");

  a_hammer_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("hammer high outside a strike run");

  a_run_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    strikes_left != 8'd0 |=> strikes_left <= $past(strikes_left))
    else $error("strike count grew during a run");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule
